[hdl/wqf_pkg.sv]
// Shared types, constants and arithmetic helpers of the weighted quadratic fit core.
// Used by wqf_mac, wqf_div and weighted_quadratic_fit_core; no dependencies.
`timescale 1ns / 1ps

package wqf_pkg;

  // fraction bits of point_x / point_y
  localparam int unsigned COORD_FRAC_BITS = 8;
  // wide word for determinants, numerators and quotients (seven 32-bit limbs)
  localparam int unsigned DW = 224;
  localparam int unsigned DIV_CW = $clog2(DW);

  typedef logic [DW-1:0] wide_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat64_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } coef_t;

  // one partial product issued to the shared multiplier
  typedef struct packed {
    logic        vld;
    logic [31:0] a;
    logic [31:0] b;
    logic [2:0]  sh;   // limb offset of the product
  } mac_iss_t;

  // one term of the 3x3 determinant: column used in rows 0, 1, 2 and its sign
  typedef struct packed {
    logic [1:0] c0;
    logic [1:0] c1;
    logic [1:0] c2;
    logic       neg;
  } perm_t;

  function automatic perm_t perm_lut(input logic [2:0] idx);
    perm_t r;
    case (idx)
      3'd0:    r = '{c0: 2'd0, c1: 2'd1, c2: 2'd2, neg: 1'b0};
      3'd1:    r = '{c0: 2'd1, c1: 2'd2, c2: 2'd0, neg: 1'b0};
      3'd2:    r = '{c0: 2'd2, c1: 2'd0, c2: 2'd1, neg: 1'b0};
      3'd3:    r = '{c0: 2'd0, c1: 2'd2, c2: 2'd1, neg: 1'b1};
      3'd4:    r = '{c0: 2'd1, c1: 2'd0, c2: 2'd2, neg: 1'b1};
      3'd5:    r = '{c0: 2'd2, c1: 2'd1, c2: 2'd0, neg: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic wide_t abs_wide(input wide_t v);
    return v[DW-1] ? (~v + wide_t'(1)) : v;
  endfunction

  // signed 64-bit add, clamped to the nearest bound
  function automatic sat64_t sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    sat64_t      r;
    s     = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? {s[64], {63{~s[64]}}} : s[63:0];
    return r;
  endfunction

  // apply sign to a product magnitude, floor-shift out the coordinate fraction, clamp
  function automatic sat64_t term_sat(input logic [79:0] mag, input logic neg);
    logic [80:0] v;
    logic [80:0] sh;
    sat64_t      r;
    v     = neg ? (~{1'b0, mag} + 81'd1) : {1'b0, mag};
    sh    = $signed(v) >>> COORD_FRAC_BITS;
    r.sat = (sh[80:63] != {18{sh[80]}});
    r.val = r.sat ? {sh[80], {63{~sh[80]}}} : sh[63:0];
    return r;
  endfunction

  // signed quotient from magnitude, clamped to 32 bits
  function automatic coef_t coef_sat(input wide_t q, input logic neg);
    logic  hi_zero;
    logic  ok;
    coef_t r;
    hi_zero = (q[DW-1:32] == '0);
    ok      = hi_zero && (!q[31] || (neg && (q[30:0] == 31'd0)));
    r.sat   = !ok;
    if (ok) begin
      r.val = neg ? (~q[31:0] + 32'd1) : q[31:0];
    end else begin
      r.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

[hdl/wqf_mac.sv]
// Shared 32x32 unsigned multiplier with a wide shifted accumulator.
// Depends on wqf_pkg.
`timescale 1ns / 1ps

module wqf_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  wqf_pkg::mac_iss_t iss_i,
  output wqf_pkg::wide_t    prod_o
);

  logic [63:0]    mul_q;
  logic [2:0]     sh_q;
  logic           pv_q;
  wqf_pkg::wide_t prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= iss_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_i.vld) begin
      mul_q <= iss_i.a * iss_i.b;
      sh_q  <= iss_i.sh;
    end
  end

  // add each partial product, registered in mul_q, at its limb offset
  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      prod_q <= '0;
    end else if (pv_q) begin
      prod_q <= prod_q + (wqf_pkg::wide_t'(mul_q) << {sh_q, 5'd0});
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/wqf_div.sv]
// Restoring divider on unsigned wide magnitudes, one quotient bit per cycle.
// Depends on wqf_pkg.
`timescale 1ns / 1ps

module wqf_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wqf_pkg::wide_t num_i,
  input  wqf_pkg::wide_t den_i,
  output logic           done_o,
  output wqf_pkg::wide_t quo_o
);

  localparam int unsigned DW = wqf_pkg::DW;
  localparam int unsigned CW = wqf_pkg::DIV_CW;
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic           run_q;
  logic           done_q;
  logic [CW-1:0]  cnt_q;
  wqf_pkg::wide_t rem_q;
  wqf_pkg::wide_t quo_q;
  wqf_pkg::wide_t den_q;
  logic [DW:0]    rem_sh;
  logic [DW+1:0]  diff;
  logic           ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~diff[DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the dividend into the remainder, subtract the divisor where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hdl/weighted_quadratic_fit_core.sv]
// Weighted quadratic least-squares fit. For each point transaction the seven product terms are
// built one after the other on a single 32x32 multiplier, two partial products per term, and
// s_tready_o stays low meanwhile. A point with tlast set then runs the solve on the same
// multiplier: four 3x3 determinants of six triple products each, the system determinant and,
// unless it is zero, one per coefficient, each followed by a bit-serial 224-bit division. The
// result waits in an output register, so the next set can start while it is not yet taken.
// Depends on wqf_pkg, wqf_mac and wqf_div.
`timescale 1ns / 1ps

module weighted_quadratic_fit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,   // point_x, point_y, point_weight
  input  logic        s_tlast_i,   // last_point
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [95:0] m_tdata_o,   // coef_const, coef_linear, coef_square
  output logic [1:0]  m_tuser_o    // singular, overflow
);

  localparam int unsigned DW = wqf_pkg::DW;
  localparam logic [1:0] J_DET = 2'd3;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_PADD  = 13'b0000000000010,
    ST_PQ    = 13'b0000000000100,
    ST_PP    = 13'b0000000001000,
    ST_MRUN  = 13'b0000000010000,
    ST_MWAIT = 13'b0000000100000,
    ST_TA    = 13'b0000001000000,
    ST_TB    = 13'b0000010000000,
    ST_TC    = 13'b0000100000000,
    ST_TD    = 13'b0001000000000,
    ST_DCHK  = 13'b0010000000000,
    ST_DIVW  = 13'b0100000000000,
    ST_EMIT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]  k_q, k_d;
  logic [2:0]  perm_q, perm_d;
  logic [1:0]  j_q, j_d;
  logic [1:0]  ia_q, ia_d, ia_last_q, ia_last_d;
  logic        ib_q, ib_d, ib_last_q, ib_last_d;
  logic [63:0] s_q [5];
  logic [63:0] s_d [5];
  logic [63:0] t_q [3];
  logic [63:0] t_d [3];
  logic        sat_q, sat_d;
  logic        m_vld_q, m_vld_d;

  logic [15:0]    x_q, x_d, y_q, y_d;
  logic           last_q, last_d;
  logic [63:0]    p_q, p_d;
  logic [127:0]   ma_q, ma_d;
  logic [63:0]    mb_q, mb_d;
  logic           mneg_q, mneg_d, tsign_q, tsign_d, dneg_q, dneg_d;
  wqf_pkg::wide_t acc_q, acc_d, det_q, det_d;
  logic [31:0]    coef_q [3];
  logic [31:0]    coef_d [3];
  logic           sing_q, sing_d;
  logic [95:0]    m_data_q, m_data_d;
  logic [1:0]     m_user_q, m_user_d;

  wqf_pkg::mac_iss_t iss;
  logic              mclr;
  wqf_pkg::wide_t    prod;
  logic              div_go;
  logic              div_done;
  wqf_pkg::wide_t    div_quo;
  wqf_pkg::wide_t    div_num;
  wqf_pkg::wide_t    div_den;

  wqf_pkg::perm_t  perm;
  logic [1:0]      row;
  logic [1:0]      col;
  logic [63:0]     e_val;
  logic [63:0]     e_mag;
  logic [63:0]     p_mag, x_mag, y_mag;
  wqf_pkg::sat64_t sa, tq, ta;
  wqf_pkg::coef_t  cs;

  wqf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (mclr),
    .iss_i  (iss),
    .prod_o (prod)
  );

  wqf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign div_num = wqf_pkg::abs_wide(acc_q) << 16;
  assign div_den = wqf_pkg::abs_wide(det_q);

  // matrix element for the current determinant term; column j_q holds the right-hand side
  always_comb begin
    perm = wqf_pkg::perm_lut(perm_q);
    unique case (state_q)
      ST_TA:   row = 2'd0;
      ST_TB:   row = 2'd1;
      default: row = 2'd2;
    endcase
    case (row)
      2'd0:    col = perm.c0;
      2'd1:    col = perm.c1;
      default: col = perm.c2;
    endcase
    e_val = (col == j_q) ? t_q[row] : s_q[{1'b0, row} + {1'b0, col}];
    e_mag = wqf_pkg::abs64(e_val);
  end

  assign p_mag = wqf_pkg::abs64(p_q);
  assign x_mag = wqf_pkg::abs64({{48{x_q[15]}}, x_q});
  assign y_mag = wqf_pkg::abs64({{48{y_q[15]}}, y_q});
  assign sa    = wqf_pkg::sat_add64(s_q[k_q], p_q);
  assign tq    = wqf_pkg::term_sat(prod[79:0], mneg_q);
  assign ta    = wqf_pkg::sat_add64(t_q[k_q[1:0]], tq.val);
  assign cs    = wqf_pkg::coef_sat(div_quo, dneg_q);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    k_d       = k_q;
    perm_d    = perm_q;
    j_d       = j_q;
    ia_d      = ia_q;
    ib_d      = ib_q;
    ia_last_d = ia_last_q;
    ib_last_d = ib_last_q;
    s_d       = s_q;
    t_d       = t_q;
    sat_d     = sat_q;
    m_vld_d   = m_vld_q;
    x_d       = x_q;
    y_d       = y_q;
    last_d    = last_q;
    p_d       = p_q;
    ma_d      = ma_q;
    mb_d      = mb_q;
    mneg_d    = mneg_q;
    tsign_d   = tsign_q;
    dneg_d    = dneg_q;
    acc_d     = acc_q;
    det_d     = det_q;
    coef_d    = coef_q;
    sing_d    = sing_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    iss       = '0;
    mclr      = 1'b0;
    div_go    = 1'b0;

    if (m_vld_q && m_tready_i) begin
      m_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          x_d     = s_tdata_i[15:0];
          y_d     = s_tdata_i[31:16];
          p_d     = {40'd0, s_tdata_i[47:32], 8'd0};
          last_d  = s_tlast_i;
          k_d     = 3'd0;
          state_d = ST_PADD;
        end
      end
      ST_PADD: begin
        s_d[k_q] = sa.val;
        sat_d    = sat_q | sa.sat;
        if (k_q < 3'd3) begin
          ma_d      = {64'd0, p_mag};
          mb_d      = y_mag;
          mneg_d    = p_q[63] ^ y_q[15];
          ia_last_d = 2'd1;
          ib_last_d = 1'b0;
          ia_d      = 2'd0;
          ib_d      = 1'b0;
          mclr      = 1'b1;
          ret_d     = ST_PQ;
          state_d   = ST_MRUN;
        end else if (k_q == 3'd3) begin
          ma_d      = {64'd0, p_mag};
          mb_d      = x_mag;
          mneg_d    = p_q[63] ^ x_q[15];
          ia_last_d = 2'd1;
          ib_last_d = 1'b0;
          ia_d      = 2'd0;
          ib_d      = 1'b0;
          mclr      = 1'b1;
          ret_d     = ST_PP;
          state_d   = ST_MRUN;
        end else if (last_q) begin
          j_d     = J_DET;
          perm_d  = 3'd0;
          acc_d   = '0;
          state_d = ST_TA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PQ: begin
        t_d[k_q[1:0]] = ta.val;
        sat_d         = sat_q | tq.sat | ta.sat;
        ma_d          = {64'd0, p_mag};
        mb_d          = x_mag;
        mneg_d        = p_q[63] ^ x_q[15];
        ia_last_d     = 2'd1;
        ib_last_d     = 1'b0;
        ia_d          = 2'd0;
        ib_d          = 1'b0;
        mclr          = 1'b1;
        ret_d         = ST_PP;
        state_d       = ST_MRUN;
      end
      ST_PP: begin
        p_d     = tq.val;
        sat_d   = sat_q | tq.sat;
        k_d     = k_q + 3'd1;
        state_d = ST_PADD;
      end
      ST_MRUN: begin
        iss.vld = 1'b1;
        iss.a   = ma_q[{ia_q, 5'd0} +: 32];
        iss.b   = ib_q ? mb_q[63:32] : mb_q[31:0];
        iss.sh  = {1'b0, ia_q} + {2'b00, ib_q};
        if (ib_q == ib_last_q) begin
          ib_d = 1'b0;
          ia_d = ia_q + 2'd1;
          if (ia_q == ia_last_q) begin
            state_d = ST_MWAIT;
          end
        end else begin
          ib_d = 1'b1;
        end
      end
      ST_MWAIT: begin
        // last partial product lands in this cycle
        state_d = ret_q;
      end
      ST_TA: begin
        ma_d    = {64'd0, e_mag};
        tsign_d = perm.neg ^ e_val[63];
        state_d = ST_TB;
      end
      ST_TB: begin
        mb_d      = e_mag;
        tsign_d   = tsign_q ^ e_val[63];
        ia_last_d = 2'd1;
        ib_last_d = 1'b1;
        ia_d      = 2'd0;
        ib_d      = 1'b0;
        mclr      = 1'b1;
        ret_d     = ST_TC;
        state_d   = ST_MRUN;
      end
      ST_TC: begin
        ma_d      = prod[127:0];
        mb_d      = e_mag;
        tsign_d   = tsign_q ^ e_val[63];
        ia_last_d = 2'd3;
        ib_last_d = 1'b1;
        ia_d      = 2'd0;
        ib_d      = 1'b0;
        mclr      = 1'b1;
        ret_d     = ST_TD;
        state_d   = ST_MRUN;
      end
      ST_TD: begin
        acc_d = tsign_q ? (acc_q - prod) : (acc_q + prod);
        if (perm_q == 3'd5) begin
          state_d = ST_DCHK;
        end else begin
          perm_d  = perm_q + 3'd1;
          state_d = ST_TA;
        end
      end
      ST_DCHK: begin
        if (j_q == J_DET) begin
          det_d = acc_q;
          if (acc_q == '0) begin
            coef_d  = '{default: '0};
            sing_d  = 1'b1;
            state_d = ST_EMIT;
          end else begin
            sing_d  = 1'b0;
            j_d     = 2'd0;
            perm_d  = 3'd0;
            acc_d   = '0;
            state_d = ST_TA;
          end
        end else begin
          div_go  = 1'b1;
          dneg_d  = acc_q[DW-1] ^ det_q[DW-1];
          state_d = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          coef_d[j_q] = cs.val;
          sat_d       = sat_q | cs.sat;
          if (j_q == 2'd2) begin
            state_d = ST_EMIT;
          end else begin
            j_d     = j_q + 2'd1;
            perm_d  = 3'd0;
            acc_d   = '0;
            state_d = ST_TA;
          end
        end
      end
      ST_EMIT: begin
        // hold until the output register is free, then clear the sums for the next set
        if (!m_vld_q || m_tready_i) begin
          m_data_d = {coef_q[2], coef_q[1], coef_q[0]};
          m_user_d = {sat_q, sing_q};
          m_vld_d  = 1'b1;
          s_d      = '{default: '0};
          t_d      = '{default: '0};
          sat_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      k_q       <= '0;
      perm_q    <= '0;
      j_q       <= '0;
      ia_q      <= '0;
      ib_q      <= 1'b0;
      ia_last_q <= '0;
      ib_last_q <= 1'b0;
      s_q       <= '{default: '0};
      t_q       <= '{default: '0};
      sat_q     <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      k_q       <= k_d;
      perm_q    <= perm_d;
      j_q       <= j_d;
      ia_q      <= ia_d;
      ib_q      <= ib_d;
      ia_last_q <= ia_last_d;
      ib_last_q <= ib_last_d;
      s_q       <= s_d;
      t_q       <= t_d;
      sat_q     <= sat_d;
      m_vld_q   <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    last_q   <= last_d;
    p_q      <= p_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    mneg_q   <= mneg_d;
    tsign_q  <= tsign_d;
    dneg_q   <= dneg_d;
    acc_q    <= acc_d;
    det_q    <= det_d;
    coef_q   <= coef_d;
    sing_q   <= sing_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && state_d == ST_IDLE) |=>
      (m_vld_q && !sat_q && s_q[0] == 64'd0 && t_q[0] == 64'd0))
    else $error("result emitted without clearing the sums");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && m_user_q[0]) |-> (m_data_q == 96'd0))
    else $error("singular result with nonzero coefficients");

  a_limb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MRUN) |-> (ia_q <= ia_last_q && ib_q <= ib_last_q))
    else $error("multiplier limb index past operand length");

  a_wait_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MWAIT) |-> ($past(state_q) == ST_MRUN))
    else $error("multiply drain entered without a multiply");

  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_tready_o)
    else $error("point taken while a point or solve is in progress");

endmodule
